[rtl/core/csalu_pkg.sv]
package csalu_pkg;

  // Default operand width
  localparam int DataWidth = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_SQUARE = 3'd0,
    OP_NEGATE = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_DIV    = 3'd5,
    OP_BAD6   = 3'd6,
    OP_BAD7   = 3'd7
  } op_e;

  // Status codes
  localparam logic StOk     = 1'b0;
  localparam logic StReject = 1'b1;

endpackage

[rtl/core/csalu_if.sv]
// Operand word channel
interface csalu_in_if #(
  parameter int DATA_WIDTH = csalu_pkg::DataWidth
) ();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   mode;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

// Result word channel
interface csalu_out_if #(
  parameter int DATA_WIDTH = csalu_pkg::DataWidth
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

[rtl/core/checked_signed_alu32_unit.sv]
// Channel | Dir | Word
// in_i    | in  | mode, operand_a, operand_b
// out_o   | out | value, status
//
// One word enters per cycle unless a held output backs up a full pipeline.
// The iteration pipeline does one shift-add multiply step
// and one restoring divide step per stage, DATA_WIDTH stages.
// rst_ni clears all valid bits asynchronously; payload holds no reset.
// Each stage stalls only when it is full and the stage after it is held,
// so bubbles close up and nothing is lost or repeated.
module checked_signed_alu32_unit #(
  parameter int DATA_WIDTH = csalu_pkg::DataWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  csalu_in_if.sink    in_i,
  csalu_out_if.source out_o
);
  import csalu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NS = W + 1;

  localparam logic [2*W-1:0] HalfRange = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]   MinVal    = {1'b1, {(W-1){1'b0}}};

  logic           v_q   [NS];
  logic [2:0]     op_q  [NS];
  logic           neg_q [NS];
  logic [W-1:0]   ma_q  [NS];
  logic [W-1:0]   mb_q  [NS];
  logic [2*W-1:0] acc_q [NS];
  logic [W-1:0]   rem_q [NS];
  logic [W-1:0]   quo_q [NS];
  logic [W-1:0]   fv_q  [NS];
  logic           fok_q [NS];
  logic           adv   [NS+1];

  logic           out_v_q;
  logic [W-1:0]   out_val_q;
  logic           out_st_q;

  // Build the stall chain from the output back
  always_comb begin
    adv[NS] = !out_v_q || out_o.ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  assign in_i.ready = adv[0];

  // Decode the incoming word
  logic         sa, sb;
  logic [W-1:0] a_in, b_in, ma_in, mb_in;
  logic [W:0]   fsum;
  logic         fok;
  logic         neg_in;
  always_comb begin
    a_in   = in_i.operand_a;
    b_in   = in_i.operand_b;
    sa     = a_in[W-1];
    sb     = b_in[W-1];
    ma_in  = sa ? (~a_in + 1'b1) : a_in;
    mb_in  = sb ? (~b_in + 1'b1) : b_in;
    neg_in = sa ^ sb;
    fsum   = '0;
    fok    = 1'b0;
    case (in_i.mode)
      OP_SQUARE: begin
        mb_in  = ma_in;
        neg_in = 1'b0;
      end
      OP_NEGATE: begin
        fsum = {(W+1){1'b0}} - {a_in[W-1], a_in};
        fok  = (a_in != MinVal);
      end
      OP_ADD: begin
        fsum = {a_in[W-1], a_in} + {b_in[W-1], b_in};
        fok  = (fsum[W] == fsum[W-1]);
      end
      OP_SUB: begin
        fsum = {a_in[W-1], a_in} - {b_in[W-1], b_in};
        fok  = (fsum[W] == fsum[W-1]);
      end
      default: begin
      end
    endcase
  end

  // Capture the decoded word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv[0]) begin
      v_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      op_q[0]  <= in_i.mode;
      neg_q[0] <= neg_in;
      ma_q[0]  <= ma_in;
      mb_q[0]  <= mb_in;
      acc_q[0] <= '0;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      fv_q[0]  <= fsum[W-1:0];
      fok_q[0] <= fok;
    end
  end

  // One multiply step and one divide step per stage
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [2*W-1:0] pp;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           qbit;
    logic [2*W-1:0] acc_d;
    logic [W-1:0]   rem_d;
    logic [W-1:0]   quo_d;

    always_comb begin
      pp    = mb_q[k][k] ? ({{W{1'b0}}, ma_q[k]} << k) : '0;
      acc_d = acc_q[k] + pp;
      trial = {rem_q[k], ma_q[k][W-1-k]};
      diff  = trial - {1'b0, mb_q[k]};
      qbit  = (trial >= {1'b0, mb_q[k]});
      rem_d = qbit ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[k][W-2:0], qbit};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv[k+1]) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k+1]) begin
        op_q[k+1]  <= op_q[k];
        neg_q[k+1] <= neg_q[k];
        ma_q[k+1]  <= ma_q[k];
        mb_q[k+1]  <= mb_q[k];
        acc_q[k+1] <= acc_d;
        rem_q[k+1] <= rem_d;
        quo_q[k+1] <= quo_d;
        fv_q[k+1]  <= fv_q[k];
        fok_q[k+1] <= fok_q[k];
      end
    end
  end

  // Range check, then sign the finished magnitude or take the sum or negation
  logic [2*W-1:0] mag;
  logic [2*W-1:0] lim;
  logic           ok_d;
  logic [W-1:0]   val_d;
  always_comb begin
    mag   = (op_q[NS-1] == OP_DIV) ? {{W{1'b0}}, quo_q[NS-1]} : acc_q[NS-1];
    lim   = (neg_q[NS-1] && (mag != '0)) ? HalfRange : HalfRange - 1'b1;
    ok_d  = 1'b0;
    val_d = '0;
    case (op_q[NS-1]) inside
      OP_SQUARE, OP_MUL: begin
        ok_d = (mag <= lim);
      end
      OP_DIV: begin
        ok_d = (mag <= lim) && (mb_q[NS-1] != '0);
      end
      OP_NEGATE, OP_ADD, OP_SUB: begin
        ok_d = fok_q[NS-1];
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (ok_d) begin
      if (op_q[NS-1] == OP_NEGATE || op_q[NS-1] == OP_ADD || op_q[NS-1] == OP_SUB) begin
        val_d = fv_q[NS-1];
      end else begin
        val_d = neg_q[NS-1] ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv[NS]) begin
      out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS]) begin
      out_val_q <= val_d;
      out_st_q  <= ok_d ? StOk : StReject;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.value  = out_val_q;
  assign out_o.status = out_st_q;

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csalu_pkg::*;

  localparam int W = DataWidth;
  localparam logic signed [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                status;
  } alu_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  csalu_in_if  #(.DATA_WIDTH(W)) in_ch ();
  csalu_out_if #(.DATA_WIDTH(W)) out_ch ();

  checked_signed_alu32_unit #(.DATA_WIDTH(W)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  alu_word_t expected_q[$];
  int        mismatches = 0;
  int        cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = OP_SQUARE;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
  end

  // Clock and cycle limit
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Compute the exact result in double width and range-check it
  function automatic alu_word_t alu_result(op_e op, logic signed [W-1:0] a,
                                           logic signed [W-1:0] b);
    logic signed [2*W+1:0] wide;
    logic signed [2*W+1:0] wa;
    logic signed [2*W+1:0] wb;
    logic                  ok;
    alu_word_t             r;
    wa = a;
    wb = b;
    wide = '0;
    ok = 1'b1;
    case (op)
      OP_SQUARE: wide = wa * wa;
      OP_NEGATE: wide = -wa;
      OP_ADD:    wide = wa + wb;
      OP_SUB:    wide = wa - wb;
      OP_MUL:    wide = wa * wb;
      OP_DIV: begin
        if (b == 0) ok = 1'b0;
        else wide = wa / wb;
      end
      default:   ok = 1'b0;
    endcase
    if (ok && (wide > $signed({{(W+2){1'b0}}, MaxVal}) ||
               wide < $signed({{(W+2){1'b1}}, MinVal})))
      ok = 1'b0;
    r.value = ok ? wide[W-1:0] : '0;
    r.status = ok ? StOk : StReject;
    return r;
  endfunction

  task automatic report(string what, alu_word_t got, alu_word_t want);
    mismatches++;
    $display("mismatch %s: got value %0d status %0b, want value %0d status %0b",
             what, got.value, got.status, want.value, want.status);
  endtask

  // Drain results with random stalls and compare
  initial begin
    alu_word_t got;
    alu_word_t want;
    int        stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got.value = out_ch.value;
      got.status = out_ch.status;
      if (expected_q.size() == 0) begin
        report("unexpected word", got, got);
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value) report("value", got, want);
        if (got.status !== want.status) report("status", got, want);
      end
    end
  end

  int gap_max = 12;

  // Send one word and queue its expected result
  task automatic send_word(op_e op, logic signed [W-1:0] a, logic signed [W-1:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(alu_result(op, a, b));
  endtask

  function automatic logic signed [W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MaxVal;
      1: return MinVal;
      2: return $signed(W'($urandom_range(0, 3))) - 1;
      3: return MinVal + $urandom_range(0, 2);
      4: return $signed(W'($urandom_range(0, 65535))) - 32768;
      5: return $signed(W'($urandom_range(0, 1 << 17))) - (1 << 16);
      default: return $signed(W'($urandom));
    endcase
  endfunction

  task automatic test_directed_edges();
    for (int o = 0; o < 8; o++) send_word(op_e'(o), 7, -3);
    send_word(OP_NEGATE, MinVal, 0);
    send_word(OP_NEGATE, MaxVal, 0);
    send_word(OP_DIV, MinVal, -1);
    send_word(OP_DIV, 5, 0);
    send_word(OP_DIV, -7, 2);
    send_word(OP_ADD, MaxVal, 1);
    send_word(OP_SUB, MinVal, 1);
    send_word(OP_MUL, MinVal, 1);
    send_word(OP_MUL, MinVal, -1);
    send_word(OP_SQUARE, 46341, 0);
    send_word(OP_SQUARE, -46340, 0);
    send_word(OP_MUL, 65536, -32768);
    send_word(OP_MUL, 65536, 32768);
  endtask

  task automatic test_random_words(int count);
    for (int i = 0; i < count; i++) begin
      gap_max = (i % 200 < 40) ? 0 : 12;
      send_word(op_e'($urandom_range(0, 7)), pick_operand(), pick_operand());
    end
    gap_max = 12;
  endtask

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_words(1600);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * W + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
